[design/scb_pkg.sv]
// Shared constants, types and register codes for the scaled sprite blitter.
package scb_pkg;

   localparam int MAX_ZOOM       = 8;
   localparam int MAX_SPRITE_DIM = 512;
   localparam int MAX_SCREEN_DIM = 4096;

   localparam int ALPHA_SHIFT = 24;
   localparam logic [7:0] ALPHA_MASK = 8'hFF;

   localparam int COLOR_W  = 32;
   localparam int RGB_W    = 24;
   localparam int COORD_W  = 12;
   localparam int CNT_W    = 9;
   localparam int CALC_W   = 16;
   localparam int ZOOM_W   = 4;
   localparam int SPRITE_W = 10;
   localparam int SCREEN_W = 13;
   localparam int ORIGIN_W = 13;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   typedef enum logic [2:0] {
      REG_ORIGIN_X      = 3'd0,
      REG_ORIGIN_Y      = 3'd1,
      REG_SPRITE_WIDTH  = 3'd2,
      REG_SPRITE_HEIGHT = 3'd3,
      REG_ZOOM          = 3'd4,
      REG_SCREEN_WIDTH  = 3'd5,
      REG_SCREEN_HEIGHT = 3'd6
   } reg_index_type;

   // Configuration after range limiting.
   typedef struct packed {
      logic signed [ORIGIN_W-1:0] origin_x;
      logic signed [ORIGIN_W-1:0] origin_y;
      logic [ZOOM_W-1:0]          zoom;
      logic [SPRITE_W-1:0]        sprite_w;
      logic [SPRITE_W-1:0]        sprite_h;
      logic [SCREEN_W-1:0]        screen_w;
      logic [SCREEN_W-1:0]        screen_h;
   } cfg_type;

   // One clipped block: inclusive corner coordinates plus color.
   typedef struct packed {
      logic [COORD_W-1:0] x0;
      logic [COORD_W-1:0] x1;
      logic [COORD_W-1:0] y0;
      logic [COORD_W-1:0] y1;
      logic [RGB_W-1:0]   color;
   } blk_type;

   // Queue status seen by its producer and consumer.
   typedef struct packed {
      logic full;
      logic valid;
   } q_stat_type;

endpackage

[design/scaled_sprite_blitter.sv]
// Scaled sprite blitter top level: register file, front end, queue, back end.
//
// Sprite pixels come in as req beats in raster order; a pixel whose alpha
// byte is zero is drawn as a zoom-by-zoom block at origin + position*zoom,
// clipped to the screen, and each surviving screen write leaves as one rsp
// beat, rows first, with last_of_run set on the final beat of that pixel.
// Transparent or fully clipped pixels produce no beats but still advance the
// sprite column/row counters. The front end takes one pixel per cycle, unless
// a held pixel waits on a full queue, into a two-step setup (position
// multiply, then clip) and parks drawn blocks in a 4-entry queue; the back
// end pulls a block and then emits one write beat per cycle while rsp_ready
// allows. The back-end walker sets sustained throughput; the queue lets
// pixels that draw nothing flow through the front at one per cycle meanwhile,
// while it is not full. The user must write registers over the APB port only
// while no pixel is in flight; the block itself does not enforce this.
module scaled_sprite_blitter (
   input  logic                        clock,
   input  logic                        reset,
   // pixel input channel
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [scb_pkg::COLOR_W-1:0] req_pixel_color,
   // screen write channel
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [scb_pkg::COORD_W-1:0] rsp_dest_x,
   output logic [scb_pkg::COORD_W-1:0] rsp_dest_y,
   output logic [scb_pkg::RGB_W-1:0]   rsp_dest_color,
   output logic                        rsp_last_of_run,
   // register port
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [4:0]                  paddr,
   input  logic [31:0]                 pwdata,
   output logic [31:0]                 prdata,
   output logic                        pready
);

   // raw register values, as written
   logic [scb_pkg::ORIGIN_W-1:0] origin_x_ff, origin_x_in;
   logic [scb_pkg::ORIGIN_W-1:0] origin_y_ff, origin_y_in;
   logic [scb_pkg::SPRITE_W-1:0] sprite_w_ff, sprite_w_in;
   logic [scb_pkg::SPRITE_W-1:0] sprite_h_ff, sprite_h_in;
   logic [scb_pkg::ZOOM_W-1:0]   zoom_ff, zoom_in;
   logic [scb_pkg::SCREEN_W-1:0] screen_w_ff, screen_w_in;
   logic [scb_pkg::SCREEN_W-1:0] screen_h_ff, screen_h_in;

   logic                   wr_en;
   scb_pkg::reg_index_type reg_idx;
   scb_pkg::cfg_type       cfg;
   scb_pkg::q_stat_type    q_stat;
   scb_pkg::blk_type       push_blk, head_blk;
   logic                   q_push, q_pop;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite && pready;
   assign reg_idx = scb_pkg::reg_index_type'(paddr[4:2]);

   always_comb begin
      origin_x_in = origin_x_ff;
      origin_y_in = origin_y_ff;
      sprite_w_in = sprite_w_ff;
      sprite_h_in = sprite_h_ff;
      zoom_in     = zoom_ff;
      screen_w_in = screen_w_ff;
      screen_h_in = screen_h_ff;
      if (wr_en) begin
         case (reg_idx)
            scb_pkg::REG_ORIGIN_X:      origin_x_in = pwdata[scb_pkg::ORIGIN_W-1:0];
            scb_pkg::REG_ORIGIN_Y:      origin_y_in = pwdata[scb_pkg::ORIGIN_W-1:0];
            scb_pkg::REG_SPRITE_WIDTH:  sprite_w_in = pwdata[scb_pkg::SPRITE_W-1:0];
            scb_pkg::REG_SPRITE_HEIGHT: sprite_h_in = pwdata[scb_pkg::SPRITE_W-1:0];
            scb_pkg::REG_ZOOM:          zoom_in     = pwdata[scb_pkg::ZOOM_W-1:0];
            scb_pkg::REG_SCREEN_WIDTH:  screen_w_in = pwdata[scb_pkg::SCREEN_W-1:0];
            scb_pkg::REG_SCREEN_HEIGHT: screen_h_in = pwdata[scb_pkg::SCREEN_W-1:0];
            default: ;  // unmapped address: write dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff <= '0;
         origin_y_ff <= '0;
         sprite_w_ff <= 10'd64;
         sprite_h_ff <= 10'd64;
         zoom_ff     <= 4'd1;
         screen_w_ff <= 13'd640;
         screen_h_ff <= 13'd480;
      end else begin
         origin_x_ff <= origin_x_in;
         origin_y_ff <= origin_y_in;
         sprite_w_ff <= sprite_w_in;
         sprite_h_ff <= sprite_h_in;
         zoom_ff     <= zoom_in;
         screen_w_ff <= screen_w_in;
         screen_h_ff <= screen_h_in;
      end
   end

   always_comb begin
      case (reg_idx)
         scb_pkg::REG_ORIGIN_X:      prdata = 32'(origin_x_ff);
         scb_pkg::REG_ORIGIN_Y:      prdata = 32'(origin_y_ff);
         scb_pkg::REG_SPRITE_WIDTH:  prdata = 32'(sprite_w_ff);
         scb_pkg::REG_SPRITE_HEIGHT: prdata = 32'(sprite_h_ff);
         scb_pkg::REG_ZOOM:          prdata = 32'(zoom_ff);
         scb_pkg::REG_SCREEN_WIDTH:  prdata = 32'(screen_w_ff);
         scb_pkg::REG_SCREEN_HEIGHT: prdata = 32'(screen_h_ff);
         default:                    prdata = '0;
      endcase
   end

   // Range limiting: zero zoom/size act as one, oversize clamps to the max.
   // Screen size zero stays zero and clips everything downstream.
   always_comb begin
      cfg.origin_x = $signed(origin_x_ff);
      cfg.origin_y = $signed(origin_y_ff);
      if (zoom_ff == '0) cfg.zoom = 4'd1;
      else if (zoom_ff > scb_pkg::ZOOM_W'(scb_pkg::MAX_ZOOM))
         cfg.zoom = scb_pkg::ZOOM_W'(scb_pkg::MAX_ZOOM);
      else cfg.zoom = zoom_ff;
      if (sprite_w_ff == '0) cfg.sprite_w = 10'd1;
      else if (sprite_w_ff > scb_pkg::SPRITE_W'(scb_pkg::MAX_SPRITE_DIM))
         cfg.sprite_w = scb_pkg::SPRITE_W'(scb_pkg::MAX_SPRITE_DIM);
      else cfg.sprite_w = sprite_w_ff;
      if (sprite_h_ff == '0) cfg.sprite_h = 10'd1;
      else if (sprite_h_ff > scb_pkg::SPRITE_W'(scb_pkg::MAX_SPRITE_DIM))
         cfg.sprite_h = scb_pkg::SPRITE_W'(scb_pkg::MAX_SPRITE_DIM);
      else cfg.sprite_h = sprite_h_ff;
      if (screen_w_ff > scb_pkg::SCREEN_W'(scb_pkg::MAX_SCREEN_DIM))
         cfg.screen_w = scb_pkg::SCREEN_W'(scb_pkg::MAX_SCREEN_DIM);
      else cfg.screen_w = screen_w_ff;
      if (screen_h_ff > scb_pkg::SCREEN_W'(scb_pkg::MAX_SCREEN_DIM))
         cfg.screen_h = scb_pkg::SCREEN_W'(scb_pkg::MAX_SCREEN_DIM);
      else cfg.screen_h = screen_h_ff;
   end

   scb_front u_front (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_pixel_color (req_pixel_color),
      .q_stat          (q_stat),
      .q_push          (q_push),
      .q_blk           (push_blk)
   );

   scb_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_blk (push_blk),
      .pop      (q_pop),
      .head_blk (head_blk),
      .stat     (q_stat)
   );

   scb_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_stat          (q_stat),
      .q_blk           (head_blk),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_dest_x      (rsp_dest_x),
      .rsp_dest_y      (rsp_dest_y),
      .rsp_dest_color  (rsp_dest_color),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

[design/scb_front.sv]
// Front end: pixel intake, sprite counters, alpha test and clip-range setup.
module scb_front (
   input  logic                     clock,
   input  logic                     reset,
   input  scb_pkg::cfg_type         cfg,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [scb_pkg::COLOR_W-1:0] req_pixel_color,
   input  scb_pkg::q_stat_type      q_stat,
   output logic                     q_push,
   output scb_pkg::blk_type         q_blk
);

   logic [scb_pkg::CNT_W-1:0] col_ff, col_in;
   logic [scb_pkg::CNT_W-1:0] row_ff, row_in;
   logic                      s1_valid_ff, s1_valid_in;
   logic                      draw_ff;
   logic signed [scb_pkg::CALC_W-1:0] bx_ff, by_ff;
   logic [scb_pkg::RGB_W-1:0] color_ff;

   logic accept, s1_move;
   logic [scb_pkg::ORIGIN_W-1:0] prod_x, prod_y;
   logic signed [scb_pkg::CALC_W-1:0] bx_in, by_in;
   logic [scb_pkg::CNT_W:0] col_inc, row_inc;
   logic signed [scb_pkg::CALC_W-1:0] zoff, x_hi, y_hi, x_lim, y_lim;
   logic signed [scb_pkg::CALC_W-1:0] x_lo, y_lo, x_top, y_top;
   logic hit;

   assign s1_move   = s1_valid_ff && !q_stat.full;
   assign req_ready = !s1_valid_ff || !q_stat.full;
   assign accept    = req_valid && req_ready;

   assign prod_x = {4'b0, col_ff} * {9'b0, cfg.zoom};
   assign prod_y = {4'b0, row_ff} * {9'b0, cfg.zoom};
   assign bx_in  = scb_pkg::CALC_W'(cfg.origin_x) + $signed({3'b0, prod_x});
   assign by_in  = scb_pkg::CALC_W'(cfg.origin_y) + $signed({3'b0, prod_y});

   // Counters wrap at the sprite size, also when they already sit past it.
   assign col_inc = {1'b0, col_ff} + 10'd1;
   assign row_inc = {1'b0, row_ff} + 10'd1;
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (col_inc >= cfg.sprite_w) begin
            col_in = '0;
            row_in = (row_inc >= cfg.sprite_h) ? '0 : row_inc[scb_pkg::CNT_W-1:0];
         end else begin
            col_in = col_inc[scb_pkg::CNT_W-1:0];
         end
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) s1_valid_in = 1'b1;
      else if (s1_move) s1_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         bx_ff    <= bx_in;
         by_ff    <= by_in;
         color_ff <= req_pixel_color[scb_pkg::RGB_W-1:0];
         draw_ff  <= ((req_pixel_color >> scb_pkg::ALPHA_SHIFT) & 32'(scb_pkg::ALPHA_MASK))
                     == '0;
      end
   end

   // Clip the block to the screen; an empty range on either axis drops it.
   assign zoff  = $signed({12'b0, cfg.zoom}) - 16'sd1;
   assign x_hi  = bx_ff + zoff;
   assign y_hi  = by_ff + zoff;
   assign x_lim = $signed({3'b0, cfg.screen_w}) - 16'sd1;
   assign y_lim = $signed({3'b0, cfg.screen_h}) - 16'sd1;
   assign x_lo  = bx_ff[scb_pkg::CALC_W-1] ? '0 : bx_ff;
   assign y_lo  = by_ff[scb_pkg::CALC_W-1] ? '0 : by_ff;
   assign x_top = (x_hi < x_lim) ? x_hi : x_lim;
   assign y_top = (y_hi < y_lim) ? y_hi : y_lim;
   assign hit   = (x_lo <= x_top) && (y_lo <= y_top);

   assign q_push      = s1_move && draw_ff && hit;
   assign q_blk.x0    = x_lo[scb_pkg::COORD_W-1:0];
   assign q_blk.x1    = x_top[scb_pkg::COORD_W-1:0];
   assign q_blk.y0    = y_lo[scb_pkg::COORD_W-1:0];
   assign q_blk.y1    = y_top[scb_pkg::COORD_W-1:0];
   assign q_blk.color = color_ff;

endmodule

[design/scb_queue.sv]
// Small block queue between front and back end.
module scb_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  scb_pkg::blk_type    push_blk,
   input  logic                pop,
   output scb_pkg::blk_type    head_blk,
   output scb_pkg::q_stat_type stat
);

   scb_pkg::blk_type entry_ff [scb_pkg::QUEUE_DEPTH];
   logic [scb_pkg::QUEUE_AW-1:0] wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [scb_pkg::QUEUE_AW:0]   count_ff, count_in;
   logic do_push, do_pop;

   assign stat.full  = (count_ff == (scb_pkg::QUEUE_AW+1)'(scb_pkg::QUEUE_DEPTH));
   assign stat.valid = (count_ff != '0);
   assign do_push    = push && !stat.full;
   assign do_pop     = pop && stat.valid;
   assign head_blk   = entry_ff[rptr_ff];

   always_comb begin
      wptr_in  = do_push ? wptr_ff + 1'b1 : wptr_ff;
      rptr_in  = do_pop ? rptr_ff + 1'b1 : rptr_ff;
      count_in = count_ff;
      if (do_push && !do_pop) count_in = count_ff + 1'b1;
      else if (do_pop && !do_push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) entry_ff[wptr_ff] <= push_blk;
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      stat.full |-> !push)
      else $error("push into full queue");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (scb_pkg::QUEUE_AW+1)'(scb_pkg::QUEUE_DEPTH))
      else $error("queue count past depth");

endmodule

[design/scb_back.sv]
// Back end: walks each clipped block row by row into registered write beats.
module scb_back (
   input  logic                        clock,
   input  logic                        reset,
   input  scb_pkg::q_stat_type         q_stat,
   input  scb_pkg::blk_type            q_blk,
   output logic                        q_pop,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [scb_pkg::COORD_W-1:0] rsp_dest_x,
   output logic [scb_pkg::COORD_W-1:0] rsp_dest_y,
   output logic [scb_pkg::RGB_W-1:0]   rsp_dest_color,
   output logic                        rsp_last_of_run
);

   logic busy_ff, busy_in;
   logic [scb_pkg::COORD_W-1:0] cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   scb_pkg::blk_type blk_ff;
   logic rsp_valid_ff, rsp_valid_in;
   logic [scb_pkg::COORD_W-1:0] out_x_ff, out_y_ff;
   logic [scb_pkg::RGB_W-1:0]   out_color_ff;
   logic out_last_ff;
   logic emit, row_end, last;

   assign q_pop   = !busy_ff && q_stat.valid;
   assign emit    = busy_ff && (!rsp_valid_ff || rsp_ready);
   assign row_end = (cur_x_ff == blk_ff.x1);
   assign last    = row_end && (cur_y_ff == blk_ff.y1);

   always_comb begin
      busy_in  = busy_ff;
      cur_x_in = cur_x_ff;
      cur_y_in = cur_y_ff;
      if (q_pop) begin
         busy_in  = 1'b1;
         cur_x_in = q_blk.x0;
         cur_y_in = q_blk.y0;
      end else if (emit) begin
         if (last) begin
            busy_in = 1'b0;
         end else if (row_end) begin
            cur_x_in = blk_ff.x0;
            cur_y_in = cur_y_ff + 1'b1;
         end else begin
            cur_x_in = cur_x_ff + 1'b1;
         end
      end
      rsp_valid_in = rsp_valid_ff;
      if (emit) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_x_ff <= cur_x_in;
      cur_y_ff <= cur_y_in;
      if (q_pop) blk_ff <= q_blk;
      if (emit) begin
         out_x_ff     <= cur_x_ff;
         out_y_ff     <= cur_y_ff;
         out_color_ff <= blk_ff.color;
         out_last_ff  <= last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_dest_x      = out_x_ff;
   assign rsp_dest_y      = out_y_ff;
   assign rsp_dest_color  = out_color_ff;
   assign rsp_last_of_run = out_last_ff;

   a_x_in_block: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (cur_x_ff >= blk_ff.x0) && (cur_x_ff <= blk_ff.x1))
      else $error("walk column left the block");

   a_y_in_block: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (cur_y_ff >= blk_ff.y0) && (cur_y_ff <= blk_ff.y1))
      else $error("walk row left the block");

   a_last_frees: assert property (@(posedge clock) disable iff (reset)
      (emit && last) |=> !busy_ff || $past(q_pop))
      else $error("walker still busy after last beat");

endmodule
